// ----- rtl/core/gso_pkg.sv -----
package gso_pkg;

   // field widths
   localparam int IN_WIDTH  = 16;
   localparam int FRAC_BITS = 14;
   localparam int OUT_W     = 16;

   // internal datapath widths
   localparam int PROD_W  = 2 * IN_WIDTH;
   localparam int DOT_W   = PROD_W + 2;
   localparam int CROSS_W = PROD_W + 1;
   localparam int DIR_W   = DOT_W + IN_WIDTH + 2;

   // normalizer step counts
   localparam int SHIFT_STEPS = 6;
   localparam int SQRT_STEPS  = 32;
   localparam int QUO_W       = FRAC_BITS + 1;

   // pipeline depths
   localparam int DIR_LAT   = 5;
   localparam int NORM_LAT  = 1 + SHIFT_STEPS + 2 + SQRT_STEPS + 1 + QUO_W + 1;
   localparam int TOTAL_LAT = DIR_LAT + NORM_LAT;

   typedef logic signed [IN_WIDTH-1:0] in_type;
   typedef logic signed [DIR_W-1:0]    dir_type;
   typedef logic signed [OUT_W-1:0]    out_type;

endpackage

// ----- rtl/core/gram_schmidt_orthonormalize_3d_unit.sv -----
// Throughput: one triple per cycle; busy is always low.
// Rate is set by a fully pipelined datapath: 5 stages form the three
// directions, then 58 normalizer stages (shift, square, 32 root, 15 divide).
// Reset (synchronous, active high) clears the valid chain; data is not cleared.
// The receiver cannot stall; every result shows for exactly one cycle.
module gram_schmidt_orthonormalize_3d_unit import gso_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  in_type  req_in_a_x,
   input  in_type  req_in_a_y,
   input  in_type  req_in_a_z,
   input  in_type  req_in_b_x,
   input  in_type  req_in_b_y,
   input  in_type  req_in_b_z,
   input  in_type  req_in_c_x,
   input  in_type  req_in_c_y,
   input  in_type  req_in_c_z,
   output logic    rsp_strobe,
   output out_type rsp_out_u_x,
   output out_type rsp_out_u_y,
   output out_type rsp_out_u_z,
   output out_type rsp_out_v_x,
   output out_type rsp_out_v_y,
   output out_type rsp_out_v_z,
   output out_type rsp_out_w_x,
   output out_type rsp_out_w_y,
   output out_type rsp_out_w_z,
   output logic    rsp_degenerate
);

   logic [TOTAL_LAT-1:0] vld_ff;

   in_type a_c [3];
   in_type b_c [3];
   in_type c_c [3];

   // stage 1
   in_type a1_ff [3];
   in_type b1_ff [3];
   in_type c1_ff [3];
   logic signed [PROD_W-1:0] aa_ff [3];
   logic signed [PROD_W-1:0] ab_ff [3];
   logic signed [PROD_W-1:0] ac_ff [3];
   logic signed [PROD_W-1:0] bb_ff [3];
   logic signed [PROD_W-1:0] bc_ff [3];
   logic signed [PROD_W-1:0] cxp_ff [3];
   logic signed [PROD_W-1:0] cxm_ff [3];

   // stage 2
   in_type a2_ff [3];
   in_type b2_ff [3];
   in_type c2_ff [3];
   logic signed [DOT_W-1:0]   dd_ff;
   logic signed [DOT_W-1:0]   dab_ff;
   logic signed [DOT_W-1:0]   dac_ff;
   logic signed [DOT_W-1:0]   dbb_ff;
   logic signed [DOT_W-1:0]   dbc_ff;
   logic signed [CROSS_W-1:0] n2_ff [3];

   // stage 3
   in_type a3_ff [3];
   in_type b3_ff [3];
   in_type c3_ff [3];
   logic signed [CROSS_W-1:0] n3_ff [3];
   dir_type p_ddb_ff [3];
   dir_type p_aba_ff [3];
   dir_type p_ddc_ff [3];
   dir_type p_aca_ff [3];
   dir_type p_bbc_ff [3];
   dir_type p_bcb_ff [3];
   dir_type p_nc_ff  [3];

   // stage 4
   in_type a4_ff [3];
   in_type b4_ff [3];
   in_type c4_ff [3];
   logic signed [CROSS_W-1:0] n4_ff [3];
   dir_type rab_ff [3];
   dir_type rac_ff [3];
   dir_type rbc_ff [3];
   dir_type sd_ff;

   // stage 5
   dir_type bd_c [3];
   dir_type cd_c [3];
   logic    anz_c;
   logic    bnz_c;
   dir_type a5_ff [3];
   dir_type b5_ff [3];
   dir_type c5_ff [3];

   out_type u_q [3];
   out_type v_q [3];
   out_type w_q [3];
   logic    u_nz, v_nz, w_nz;

   assign busy = 1'b0;

   assign a_c = '{req_in_a_x, req_in_a_y, req_in_a_z};
   assign b_c = '{req_in_b_x, req_in_b_y, req_in_b_z};
   assign c_c = '{req_in_c_x, req_in_c_y, req_in_c_z};

   // advance the valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], start & ~busy};
      end
   end

   // stage 1: elementwise products and cross terms
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a1_ff[i] <= a_c[i];
         b1_ff[i] <= b_c[i];
         c1_ff[i] <= c_c[i];
         aa_ff[i] <= PROD_W'(a_c[i]) * PROD_W'(a_c[i]);
         ab_ff[i] <= PROD_W'(a_c[i]) * PROD_W'(b_c[i]);
         ac_ff[i] <= PROD_W'(a_c[i]) * PROD_W'(c_c[i]);
         bb_ff[i] <= PROD_W'(b_c[i]) * PROD_W'(b_c[i]);
         bc_ff[i] <= PROD_W'(b_c[i]) * PROD_W'(c_c[i]);
      end
      cxp_ff[0] <= PROD_W'(a_c[1]) * PROD_W'(b_c[2]);
      cxm_ff[0] <= PROD_W'(a_c[2]) * PROD_W'(b_c[1]);
      cxp_ff[1] <= PROD_W'(a_c[2]) * PROD_W'(b_c[0]);
      cxm_ff[1] <= PROD_W'(a_c[0]) * PROD_W'(b_c[2]);
      cxp_ff[2] <= PROD_W'(a_c[0]) * PROD_W'(b_c[1]);
      cxm_ff[2] <= PROD_W'(a_c[1]) * PROD_W'(b_c[0]);
   end

   // stage 2: dot products and the normal a x b
   always_ff @(posedge clock) begin
      a2_ff  <= a1_ff;
      b2_ff  <= b1_ff;
      c2_ff  <= c1_ff;
      dd_ff  <= DOT_W'(aa_ff[0]) + DOT_W'(aa_ff[1]) + DOT_W'(aa_ff[2]);
      dab_ff <= DOT_W'(ab_ff[0]) + DOT_W'(ab_ff[1]) + DOT_W'(ab_ff[2]);
      dac_ff <= DOT_W'(ac_ff[0]) + DOT_W'(ac_ff[1]) + DOT_W'(ac_ff[2]);
      dbb_ff <= DOT_W'(bb_ff[0]) + DOT_W'(bb_ff[1]) + DOT_W'(bb_ff[2]);
      dbc_ff <= DOT_W'(bc_ff[0]) + DOT_W'(bc_ff[1]) + DOT_W'(bc_ff[2]);
      for (int i = 0; i < 3; i++) begin
         n2_ff[i] <= CROSS_W'(cxp_ff[i]) - CROSS_W'(cxm_ff[i]);
      end
   end

   // stage 3: scale the vectors for the rejections
   always_ff @(posedge clock) begin
      a3_ff <= a2_ff;
      b3_ff <= b2_ff;
      c3_ff <= c2_ff;
      n3_ff <= n2_ff;
      for (int i = 0; i < 3; i++) begin
         p_ddb_ff[i] <= DIR_W'(dd_ff) * DIR_W'(b2_ff[i]);
         p_aba_ff[i] <= DIR_W'(dab_ff) * DIR_W'(a2_ff[i]);
         p_ddc_ff[i] <= DIR_W'(dd_ff) * DIR_W'(c2_ff[i]);
         p_aca_ff[i] <= DIR_W'(dac_ff) * DIR_W'(a2_ff[i]);
         p_bbc_ff[i] <= DIR_W'(dbb_ff) * DIR_W'(c2_ff[i]);
         p_bcb_ff[i] <= DIR_W'(dbc_ff) * DIR_W'(b2_ff[i]);
         p_nc_ff[i]  <= DIR_W'(n2_ff[i]) * DIR_W'(c2_ff[i]);
      end
   end

   // stage 4: rejections and the side of c against the normal
   always_ff @(posedge clock) begin
      a4_ff <= a3_ff;
      b4_ff <= b3_ff;
      c4_ff <= c3_ff;
      n4_ff <= n3_ff;
      for (int i = 0; i < 3; i++) begin
         rab_ff[i] <= p_ddb_ff[i] - p_aba_ff[i];
         rac_ff[i] <= p_ddc_ff[i] - p_aca_ff[i];
         rbc_ff[i] <= p_bbc_ff[i] - p_bcb_ff[i];
      end
      sd_ff <= p_nc_ff[0] + p_nc_ff[1] + p_nc_ff[2];
   end

   // stage 5: pick the second and third directions
   always_comb begin
      anz_c = (a4_ff[0] != '0) || (a4_ff[1] != '0) || (a4_ff[2] != '0);
      for (int i = 0; i < 3; i++) begin
         bd_c[i] = anz_c ? rab_ff[i] : DIR_W'(b4_ff[i]);
      end
      bnz_c = (bd_c[0] != '0) || (bd_c[1] != '0) || (bd_c[2] != '0);
      for (int i = 0; i < 3; i++) begin
         priority if (anz_c && bnz_c) begin
            if (sd_ff > 0)      cd_c[i] = DIR_W'(n4_ff[i]);
            else if (sd_ff < 0) cd_c[i] = -DIR_W'(n4_ff[i]);
            else                cd_c[i] = '0;
         end else if (anz_c) begin
            cd_c[i] = rac_ff[i];
         end else if (bnz_c) begin
            cd_c[i] = rbc_ff[i];
         end else begin
            cd_c[i] = DIR_W'(c4_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a5_ff[i] <= DIR_W'(a4_ff[i]);
         b5_ff[i] <= bd_c[i];
         c5_ff[i] <= cd_c[i];
      end
   end

   gso_norm u_norm_a (.clock(clock), .vec_in(a5_ff), .q_out(u_q), .nz_out(u_nz));
   gso_norm u_norm_b (.clock(clock), .vec_in(b5_ff), .q_out(v_q), .nz_out(v_nz));
   gso_norm u_norm_c (.clock(clock), .vec_in(c5_ff), .q_out(w_q), .nz_out(w_nz));

   assign rsp_strobe     = vld_ff[TOTAL_LAT-1];
   assign rsp_out_u_x    = u_q[0];
   assign rsp_out_u_y    = u_q[1];
   assign rsp_out_u_z    = u_q[2];
   assign rsp_out_v_x    = v_q[0];
   assign rsp_out_v_y    = v_q[1];
   assign rsp_out_v_z    = v_q[2];
   assign rsp_out_w_x    = w_q[0];
   assign rsp_out_w_y    = w_q[1];
   assign rsp_out_w_z    = w_q[2];
   assign rsp_degenerate = ~(u_nz & v_nz & w_nz);

   // a nonzero first vector never comes out all zero
   a_u_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && u_nz |->
         (rsp_out_u_x != '0) || (rsp_out_u_y != '0) || (rsp_out_u_z != '0))
      else $error("nonzero first vector normalized to zero");

   // the x and y components of the third vector stay within one in Q1.14
   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_out_w_x <= 16'sd16384) && (rsp_out_w_x >= -16'sd16384) &&
                     (rsp_out_w_y <= 16'sd16384) && (rsp_out_w_y >= -16'sd16384))
      else $error("third vector component out of range");

   // reset empties the pipeline
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // a degenerate second vector comes out all zero and raises the degenerate flag
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !v_nz |->
         (rsp_out_v_x == '0) && (rsp_out_v_y == '0) && (rsp_out_v_z == '0) &&
         rsp_degenerate)
      else $error("degenerate second vector not zeroed");

endmodule

// ----- rtl/core/gso_norm.sv -----
module gso_norm import gso_pkg::*; (
   input  logic    clock,
   input  dir_type vec_in [3],
   output out_type q_out [3],
   output logic    nz_out
);

   localparam int MW     = 64;
   localparam int M_W    = 31;
   localparam int SQ_W   = 2 * M_W;
   localparam int S_W    = 32;
   localparam int NUM_W  = M_W + FRAC_BITS + 3;
   localparam int DEN_W  = S_W + 1;

   logic [DIR_W-1:0] mag_c [3];
   logic [DIR_W-1:0] mx_c;

   logic [MW-1:0] sh_m_ff   [SHIFT_STEPS+1][3];
   logic          sh_neg_ff [SHIFT_STEPS+1][3];
   logic [MW-1:0] sh_mx_ff  [SHIFT_STEPS+1];
   logic          sh_nz_ff  [SHIFT_STEPS+1];

   logic [SQ_W-1:0] sq_ff     [3];
   logic [M_W-1:0]  sq_m_ff   [3];
   logic            sq_neg_ff [3];
   logic            sq_nz_ff;

   logic [MW-1:0]  rt_rem_ff [SQRT_STEPS+1];
   logic [MW-1:0]  rt_res_ff [SQRT_STEPS+1];
   logic [M_W-1:0] rt_m_ff   [SQRT_STEPS+1][3];
   logic           rt_neg_ff [SQRT_STEPS+1][3];
   logic           rt_nz_ff  [SQRT_STEPS+1];

   logic [NUM_W-1:0] dv_rem_ff [QUO_W+1][3];
   logic [QUO_W-1:0] dv_q_ff   [QUO_W+1][3];
   logic [DEN_W-1:0] dv_den_ff [QUO_W+1];
   logic             dv_neg_ff [QUO_W+1][3];
   logic             dv_nz_ff  [QUO_W+1];

   logic [S_W-1:0] root_c;

   // take magnitudes and the largest one
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_c[i] = vec_in[i][DIR_W-1] ? DIR_W'(-vec_in[i]) : DIR_W'(vec_in[i]);
      end
      mx_c = mag_c[0];
      if (mag_c[1] > mx_c) mx_c = mag_c[1];
      if (mag_c[2] > mx_c) mx_c = mag_c[2];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sh_m_ff[0][i]   <= MW'(mag_c[i]);
         sh_neg_ff[0][i] <= vec_in[i][DIR_W-1];
      end
      sh_mx_ff[0] <= MW'(mx_c);
      sh_nz_ff[0] <= (mx_c != '0);
   end

   // shift left until the largest magnitude has its top bit set
   for (genvar k = 0; k < SHIFT_STEPS; k++) begin : g_shift
      localparam int SH = (MW / 2) >> k;
      always_ff @(posedge clock) begin
         if (sh_mx_ff[k][MW-1 -: SH] == '0) begin
            for (int i = 0; i < 3; i++) sh_m_ff[k+1][i] <= sh_m_ff[k][i] << SH;
            sh_mx_ff[k+1] <= sh_mx_ff[k] << SH;
         end else begin
            for (int i = 0; i < 3; i++) sh_m_ff[k+1][i] <= sh_m_ff[k][i];
            sh_mx_ff[k+1] <= sh_mx_ff[k];
         end
         for (int i = 0; i < 3; i++) sh_neg_ff[k+1][i] <= sh_neg_ff[k][i];
         sh_nz_ff[k+1] <= sh_nz_ff[k];
      end
   end

   // square the scaled magnitudes
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq_m_ff[i]   <= sh_m_ff[SHIFT_STEPS][i][MW-1 -: M_W];
         sq_ff[i]     <= SQ_W'(sh_m_ff[SHIFT_STEPS][i][MW-1 -: M_W]) *
                         SQ_W'(sh_m_ff[SHIFT_STEPS][i][MW-1 -: M_W]);
         sq_neg_ff[i] <= sh_neg_ff[SHIFT_STEPS][i];
      end
      sq_nz_ff <= sh_nz_ff[SHIFT_STEPS];
   end

   // sum the squares into the root remainder
   always_ff @(posedge clock) begin
      rt_rem_ff[0] <= MW'(sq_ff[0]) + MW'(sq_ff[1]) + MW'(sq_ff[2]);
      rt_res_ff[0] <= '0;
      for (int i = 0; i < 3; i++) begin
         rt_m_ff[0][i]   <= sq_m_ff[i];
         rt_neg_ff[0][i] <= sq_neg_ff[i];
      end
      rt_nz_ff[0] <= sq_nz_ff;
   end

   // integer square root, one result bit per stage
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      localparam logic [MW-1:0] BIT = MW'(1) << (MW - 2 - 2 * j);
      logic [MW-1:0] trial_c;
      assign trial_c = rt_res_ff[j] + BIT;
      always_ff @(posedge clock) begin
         if (rt_rem_ff[j] >= trial_c) begin
            rt_rem_ff[j+1] <= rt_rem_ff[j] - trial_c;
            rt_res_ff[j+1] <= (rt_res_ff[j] >> 1) + BIT;
         end else begin
            rt_rem_ff[j+1] <= rt_rem_ff[j];
            rt_res_ff[j+1] <= rt_res_ff[j] >> 1;
         end
         for (int i = 0; i < 3; i++) begin
            rt_m_ff[j+1][i]   <= rt_m_ff[j][i];
            rt_neg_ff[j+1][i] <= rt_neg_ff[j][i];
         end
         rt_nz_ff[j+1] <= rt_nz_ff[j];
      end
   end

   assign root_c = rt_res_ff[SQRT_STEPS][S_W-1:0];

   // set up the rounded quotient (2m * 2^frac + s) / 2s
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dv_rem_ff[0][i] <= (NUM_W'(rt_m_ff[SQRT_STEPS][i]) << (FRAC_BITS + 1)) +
                            NUM_W'(root_c);
         dv_q_ff[0][i]   <= '0;
         dv_neg_ff[0][i] <= rt_neg_ff[SQRT_STEPS][i];
      end
      dv_den_ff[0] <= {root_c, 1'b0};
      dv_nz_ff[0]  <= rt_nz_ff[SQRT_STEPS];
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      localparam int BP = QUO_W - 1 - j;
      logic [NUM_W-1:0] dsh_c;
      assign dsh_c = NUM_W'(dv_den_ff[j]) << BP;
      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_rem_ff[j][i] >= dsh_c) begin
               dv_rem_ff[j+1][i] <= dv_rem_ff[j][i] - dsh_c;
               dv_q_ff[j+1][i]   <= dv_q_ff[j][i] | (QUO_W'(1) << BP);
            end else begin
               dv_rem_ff[j+1][i] <= dv_rem_ff[j][i];
               dv_q_ff[j+1][i]   <= dv_q_ff[j][i];
            end
            dv_neg_ff[j+1][i] <= dv_neg_ff[j][i];
         end
         dv_den_ff[j+1] <= dv_den_ff[j];
         dv_nz_ff[j+1]  <= dv_nz_ff[j];
      end
   end

   // restore signs, zero a degenerate vector
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (!dv_nz_ff[QUO_W]) begin
            q_out[i] <= '0;
         end else if (dv_neg_ff[QUO_W][i]) begin
            q_out[i] <= -OUT_W'(dv_q_ff[QUO_W][i]);
         end else begin
            q_out[i] <= OUT_W'(dv_q_ff[QUO_W][i]);
         end
      end
      nz_out <= dv_nz_ff[QUO_W];
   end

endmodule
